/* hdl/rlab_pkg.sv */
// Package for the RGB to l-alpha-beta converter: widths, matrix coefficients,
// log2 fraction table and decorrelation scale factors. No dependencies.
package rlab_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int FRAC_BITS  = 12;
  localparam int CQ         = 16;
  localparam int LMS_BITS   = PIXEL_BITS + 18;
  localparam int POS_BITS   = 5;
  localparam int LOG_BITS   = 22;
  localparam int SUM_BITS   = 25;
  localparam int PROD_BITS  = 46;
  localparam int SH         = 36 - FRAC_BITS;
  localparam int OUT_BITS   = 16;
  localparam int NSTG       = 6;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [LMS_BITS-1:0] lms_t;
  typedef logic signed [LOG_BITS-1:0] log_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic signed [OUT_BITS-1:0] out_t;

  localparam logic [15:0] LMS_COEF [3][3] = '{
    '{16'd24976, 16'd37899, 16'd2635},
    '{16'd12891, 16'd47474, 16'd5125},
    '{16'd1579,  16'd8441,  16'd55312}
  };

  localparam logic [16:0] LOG_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  localparam logic signed [20:0] K_LUM   = 21'sd182242;
  localparam logic signed [20:0] K_ALPHA = 21'sd128865;
  localparam logic signed [20:0] K_BETA  = 21'sd223200;

endpackage

/* hdl/rlab_log2.sv */
// Two-stage fixed-point log2 of one LMS component (Q.16 in, Q.16 out).
// Depends on rlab_pkg.
module rlab_log2 (
  input  logic               clk,
  input  logic               en,
  input  rlab_pkg::lms_t     val,
  output rlab_pkg::log_t     lg
);

  logic [rlab_pkg::POS_BITS-1:0] pos;
  logic [rlab_pkg::LMS_BITS-1:0] norm;
  logic [rlab_pkg::POS_BITS-1:0] pos_r;
  logic [16:0] lo_r, diff_r;
  logic [rlab_pkg::LMS_BITS-6:0] rem_r;
  logic [rlab_pkg::LMS_BITS+11:0] prod;
  logic [17:0] interp;
  rlab_pkg::log_t lg_r;

  always_comb begin
    pos = '0;
    for (int i = 0; i < rlab_pkg::LMS_BITS; i++) begin
      if (val[i]) pos = rlab_pkg::POS_BITS'(i);
    end
    norm = val << (rlab_pkg::POS_BITS'(rlab_pkg::LMS_BITS - 1) - pos);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= pos;
      lo_r   <= rlab_pkg::LOG_TAB[5'(norm[rlab_pkg::LMS_BITS-2 -: 4])];
      diff_r <= rlab_pkg::LOG_TAB[5'(norm[rlab_pkg::LMS_BITS-2 -: 4]) + 5'd1]
              - rlab_pkg::LOG_TAB[5'(norm[rlab_pkg::LMS_BITS-2 -: 4])];
      rem_r  <= norm[rlab_pkg::LMS_BITS-6:0];
    end
  end

  // The remaining fraction bits are 21 wide here; shifting the product right by
  // their own width equals shifting right by 36 with them left-aligned to 36 bits.
  assign prod   = (rlab_pkg::LMS_BITS+12)'(diff_r) * (rlab_pkg::LMS_BITS+12)'(rem_r);
  assign interp = 18'(prod >> (rlab_pkg::LMS_BITS - 5));

  always_ff @(posedge clk) begin
    if (en) begin
      lg_r <= rlab_pkg::log_t'(($signed({1'b0, pos_r}) - 7'sd16) * 23'sd65536)
            + rlab_pkg::log_t'(lo_r) + rlab_pkg::log_t'(interp);
    end
  end

  assign lg = lg_r;

endmodule

/* hdl/rlab_finish.sv */
// Scales one decorrelation sum by its constant, rounds and saturates to Q3.12.
// Depends on rlab_pkg; two register stages.
module rlab_finish (
  input  logic                  clk,
  input  logic                  en,
  input  rlab_pkg::sum_t        sum,
  input  logic signed [20:0]    k,
  output rlab_pkg::out_t        res
);

  logic signed [rlab_pkg::PROD_BITS-1:0] prod_r, rnd;
  logic signed [rlab_pkg::PROD_BITS-rlab_pkg::SH-1:0] shf;
  rlab_pkg::out_t res_r;

  always_ff @(posedge clk) begin
    if (en) prod_r <= rlab_pkg::PROD_BITS'(sum) * rlab_pkg::PROD_BITS'(k);
  end

  assign rnd = prod_r + (rlab_pkg::PROD_BITS'(1) <<< (rlab_pkg::SH - 1));
  assign shf = rnd[rlab_pkg::PROD_BITS-1:rlab_pkg::SH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (shf > (rlab_pkg::PROD_BITS-rlab_pkg::SH)'(32767)) res_r <= 16'sh7fff;
      else if (shf < (rlab_pkg::PROD_BITS-rlab_pkg::SH)'(-32768)) res_r <= 16'sh8000;
      else res_r <= shf[15:0];
    end
  end

  assign res = res_r;

endmodule

/* hdl/rgb_to_lalphabeta.sv */
// RGB to l-alpha-beta converter, fully pipelined, no stored state.
// Throughput is one item per cycle while no stall is held. Stages: LMS matrix,
// log2 normalize, log2 interpolate, sums, scale multiply, round and saturate.
// A stall freezes the whole pipeline.
// Synchronous active-low reset clears only the stage valid bits.
module rgb_to_lalphabeta (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rlab_pkg::pix_t       in_red,
  input  rlab_pkg::pix_t       in_green,
  input  rlab_pkg::pix_t       in_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rlab_pkg::out_t       out_lum,
  output rlab_pkg::out_t       out_alpha,
  output rlab_pkg::out_t       out_beta
);

  logic [rlab_pkg::NSTG-1:0] vld_r, vld_nxt;
  logic en;
  rlab_pkg::lms_t lms_r [3];
  rlab_pkg::lms_t lms_fix [3];
  rlab_pkg::log_t lg [3];
  rlab_pkg::sum_t s_lum_r, s_alpha_r, s_beta_r;

  // Global enable: the pipeline advances unless a result waits on a stall.
  assign en       = !(vld_r[rlab_pkg::NSTG-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[rlab_pkg::NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lms_r[i] <= rlab_pkg::LMS_BITS'(rlab_pkg::LMS_COEF[i][0])
                    * rlab_pkg::LMS_BITS'(in_red)
                  + rlab_pkg::LMS_BITS'(rlab_pkg::LMS_COEF[i][1])
                    * rlab_pkg::LMS_BITS'(in_green)
                  + rlab_pkg::LMS_BITS'(rlab_pkg::LMS_COEF[i][2])
                    * rlab_pkg::LMS_BITS'(in_blue);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_log
    assign lms_fix[g] = (lms_r[g] == '0) ? rlab_pkg::LMS_BITS'(1 << rlab_pkg::CQ)
                                          : lms_r[g];
    rlab_log2 u_log (.clk(clk), .en(en), .val(lms_fix[g]), .lg(lg[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_lum_r   <= rlab_pkg::sum_t'(lg[0]) + rlab_pkg::sum_t'(lg[1])
                 + rlab_pkg::sum_t'(lg[2]);
      s_alpha_r <= rlab_pkg::sum_t'(lg[0]) + rlab_pkg::sum_t'(lg[1])
                 - (rlab_pkg::sum_t'(lg[2]) <<< 1);
      s_beta_r  <= rlab_pkg::sum_t'(lg[0]) - rlab_pkg::sum_t'(lg[1]);
    end
  end

  rlab_finish u_lum   (.clk(clk), .en(en), .sum(s_lum_r),   .k(rlab_pkg::K_LUM),
                       .res(out_lum));
  rlab_finish u_alpha (.clk(clk), .en(en), .sum(s_alpha_r), .k(rlab_pkg::K_ALPHA),
                       .res(out_alpha));
  rlab_finish u_beta  (.clk(clk), .en(en), .sum(s_beta_r),  .k(rlab_pkg::K_BETA),
                       .res(out_beta));

  assign out_valid = vld_r[rlab_pkg::NSTG-1];

endmodule

/* hdl/rlab_checker.sv */
// Port-level checker for the l-alpha-beta converter and its bind statement.
// Depends on rgb_to_lalphabeta.
module rlab_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] out_lum
);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("stall without held item");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_lum)) else $error("result changed");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind rgb_to_lalphabeta rlab_checker u_rlab_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_lum(out_lum)
);

/* tb/rgb_to_lalphabeta_tb.sv */
// Testbench for rgb_to_lalphabeta: drives pixels through the valid/stall
// handshake and checks l, alpha and beta against a built-in fixed-point predictor.
// Depends on rlab_pkg and the rgb_to_lalphabeta RTL.
module rgb_to_lalphabeta_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LATENCY = rlab_pkg::NSTG;

  typedef struct packed {
    rlab_pkg::out_t lum;
    rlab_pkg::out_t alpha;
    rlab_pkg::out_t beta;
  } lab_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rlab_pkg::pix_t in_red = '0;
  rlab_pkg::pix_t in_green = '0;
  rlab_pkg::pix_t in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rlab_pkg::out_t out_lum;
  rlab_pkg::out_t out_alpha;
  rlab_pkg::out_t out_beta;

  lab_t expected_lab[$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int quiet_cycles = 0;

  rgb_to_lalphabeta dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lum(out_lum), .out_alpha(out_alpha), .out_beta(out_beta)
  );

  always #5 clk = ~clk;

  function automatic longint log2_fixed(longint unsigned v);
    int p;
    longint unsigned f, rem;
    int idx;
    longint lo, hi;
    p = 0;
    for (int i = 0; i < 40; i++) if (v[i]) p = i;
    f = (v << (40 - p)) & ((64'd1 << 40) - 1);
    idx = int'(f >> 36) & 15;
    rem = f & ((64'd1 << 36) - 1);
    lo = longint'(rlab_pkg::LOG_TAB[idx]);
    hi = longint'(rlab_pkg::LOG_TAB[idx + 1]);
    return longint'(p - rlab_pkg::CQ) * 65536 + lo
         + longint'((unsigned'(hi - lo) * rem) >> 36);
  endfunction

  function automatic rlab_pkg::out_t scale_round_sat(longint s, longint k);
    longint x;
    x = (s * k + (64'sd1 <<< (rlab_pkg::SH - 1))) >>> rlab_pkg::SH;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return rlab_pkg::out_t'(x);
  endfunction

  function automatic lab_t predict_lab(rlab_pkg::pix_t r, rlab_pkg::pix_t g,
                                       rlab_pkg::pix_t b);
    longint lg[3];
    longint unsigned v;
    lab_t res;
    for (int i = 0; i < 3; i++) begin
      v = longint'(rlab_pkg::LMS_COEF[i][0]) * r + longint'(rlab_pkg::LMS_COEF[i][1]) * g
        + longint'(rlab_pkg::LMS_COEF[i][2]) * b;
      if (v == 0) v = 64'd1 << rlab_pkg::CQ;
      lg[i] = log2_fixed(v);
    end
    res.lum = scale_round_sat(lg[0] + lg[1] + lg[2], rlab_pkg::K_LUM);
    res.alpha = scale_round_sat(lg[0] + lg[1] - 2 * lg[2], rlab_pkg::K_ALPHA);
    res.beta = scale_round_sat(lg[0] - lg[1], rlab_pkg::K_BETA);
    return res;
  endfunction

  task automatic send_pixel(rlab_pkg::pix_t r, rlab_pkg::pix_t g, rlab_pkg::pix_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    expected_lab.push_back(predict_lab(r, g, b));
    pixels_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lab_t e;
      results_seen++;
      if (expected_lab.size() == 0) begin
        $error("unexpected result lum=%0d alpha=%0d beta=%0d",
               out_lum, out_alpha, out_beta);
        errors++;
      end else begin
        e = expected_lab.pop_front();
        if (out_lum !== e.lum) begin
          $error("lum expected %0d actual %0d", e.lum, out_lum);
          errors++;
        end
        if (out_alpha !== e.alpha) begin
          $error("alpha expected %0d actual %0d", e.alpha, out_alpha);
          errors++;
        end
        if (out_beta !== e.beta) begin
          $error("beta expected %0d actual %0d", e.beta, out_beta);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rgb_to_lalphabeta");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_lab.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    rlab_pkg::pix_t ext[4] = '{8'd0, 8'd1, 8'd128, 8'd255};
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd1);
    for (int i = 0; i < 12; i++) send_pixel(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4]);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_pixel(rlab_pkg::pix_t'($urandom_range(3)), rlab_pkg::pix_t'($urandom_range(3)),
                   rlab_pkg::pix_t'($urandom_range(3)));
      end else begin
        send_pixel(rlab_pkg::pix_t'($urandom), rlab_pkg::pix_t'($urandom),
                   rlab_pkg::pix_t'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    test_random(40);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 83;
    test_directed();
    test_random(550);
    send_idle_pct = 83;
    recv_idle_pct = 14;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(500);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d pixels incl. black, white, primaries and extremes; checked %0d results.",
             pixels_sent, results_seen);
    if (errors == 0 && expected_lab.size() == 0) begin
      $display("PASS rgb_to_lalphabeta");
    end else begin
      $display("FAIL rgb_to_lalphabeta");
    end
    $finish;
  end
endmodule
